// File: rtl/tspa_pkg.sv
// Shared types, constants and helper functions of the timer slot period allocator.
// Used by every module under rtl/; depends on nothing else.
package tspa_pkg;

    localparam int NUM_SLOTS_DEF = 9;

    localparam int ID_W       = 4;
    localparam int UNIT_W     = 4;
    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 32;
    localparam int CYC_W      = 10;
    localparam int SCALE_W    = 30;
    localparam int T_W        = SAMPLE_W + SCALE_W;   // sample time in ns
    localparam int CL_W       = CYC_W + 32;           // cycle time times width limit
    localparam int DIV_CNT_W  = $clog2(T_W);
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [CYC_W-1:0] CYC_RST = 10'd25;

    localparam logic [UNIT_W-1:0] UNIT_S  = 4'd0;
    localparam logic [UNIT_W-1:0] UNIT_MS = 4'd3;
    localparam logic [UNIT_W-1:0] UNIT_US = 4'd6;
    localparam logic [UNIT_W-1:0] UNIT_NS = 4'd9;

    localparam logic [1:0] PRESC_1   = 2'd0;
    localparam logic [1:0] PRESC_8   = 2'd1;
    localparam logic [1:0] PRESC_64  = 2'd2;
    localparam logic [1:0] PRESC_256 = 2'd3;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_SET     = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_QUERY   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_IN_USE   = 3'd2,
        ST_NOT_INIT = 3'd3,
        ST_BAD_UNIT = 3'd4,
        ST_RANGE    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_MUL,
        S_CHECK,
        S_PRESC,
        S_DIV_INIT,
        S_DIV,
        S_FINISH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic mul;
        logic fail_range;
        logic presc_next;
        logic div_init;
        logic div_step;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic calc_req;
        logic lo_bad;
        logic presc_fit;
        logic presc_last;
        logic div_last;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic id_valid;
        logic wide;
        logic all_free;
        logic first_free;
        logic first_init;
    } t_slot_stat;

    function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] u);
        logic [SCALE_W-1:0] s;
        unique case (u)
            UNIT_S:  s = 30'd1_000_000_000;
            UNIT_MS: s = 30'd1_000_000;
            UNIT_US: s = 30'd1_000;
            default: s = 30'd1;
        endcase
        return s;
    endfunction

    function automatic logic unit_ok(input logic [UNIT_W-1:0] u);
        return (u == UNIT_S) || (u == UNIT_MS) || (u == UNIT_US) || (u == UNIT_NS);
    endfunction

    function automatic logic [3:0] presc_shift(input logic [1:0] code);
        logic [3:0] s;
        unique case (code)
            PRESC_1:  s = 4'd0;
            PRESC_8:  s = 4'd3;
            PRESC_64: s = 4'd6;
            default:  s = 4'd8;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/timer_slot_period_allocator_top.sv
// Top level of the timer slot period allocator: controller, datapath, config port.
// Depends on tspa_pkg, tspa_ctrl and tspa_dp.

// The block keeps NUM_SLOTS timer slots and serves one request beat at a time:
// init, set period, release or query free. Ids below NUM_SLOTS are 16-bit
// timers, the next (NUM_SLOTS-1)/2 ids are 32-bit pairs on two neighboring
// slots. Release, query and every request that fails its slot or unit check
// go from the lookup state straight to the output state. Init and set period
// with a valid unit scale the sample time to ns (one multiply) and check it
// against the cycle time; a time below the cycle time, or a zero cycle time,
// ends there. Then the prescaler is searched one candidate per cycle; a time
// above the widest setting ends after the fourth candidate. Otherwise the time,
// shifted down by the prescaler, is divided by the cycle time with a bit-serial
// restoring divider of 62 steps. The next request beat can be taken in the
// same cycle as a result appears. The result sits in an output register, so a
// new request beat is taken while the previous result still waits downstream;
// a finished result holds in its last step until that register is taken.
// cycle_time_ns is written on the config channel, which is always ready; write
// it only while no request is in flight.
module timer_slot_period_allocator_top #(
    parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request beats
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, from bit 0: timer_id[3:0], req_time[35:4], unit[39:36]
    input  logic [tspa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser, from bit 0: mode[1:0]
    input  logic [1:0]                          s_axis_tuser,
    // result beats
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, from bit 0: status[2:0], slot_is_free[3], period_valid[4],
    // prescaler_code[6:5], period_count[38:7], is_wide[39]
    output logic [tspa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // cycle_time_ns write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tspa_pkg::CYC_W-1:0]          i_cfg_data
);

    tspa_pkg::t_cmd  cmd;
    tspa_pkg::t_stat stat;

    // config writes never stall
    assign o_cfg_ready = 1'b1;

    tspa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tspa_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: rtl/tspa_slots.sv
// Slot table: free and initialized marks with id decode and masked lookups.
// Depends on tspa_pkg.
module tspa_slots #(
    parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tspa_pkg::ID_W-1:0] i_id,
    input  logic                      i_init_wr,
    input  logic                      i_release_wr,
    output tspa_pkg::t_slot_stat      o_stat
);

    localparam int NUM_PAIRS = (NUM_SLOTS - 1) / 2;
    localparam int LAST_ID   = NUM_SLOTS + NUM_PAIRS - 1;
    localparam int XW        = tspa_pkg::ID_W + 1;

    localparam logic [XW-1:0] LAST_ID_V = XW'(LAST_ID);
    localparam logic [XW-1:0] NUM_SL_V  = XW'(NUM_SLOTS);

    logic [NUM_SLOTS-1:0]          r_free;
    logic [NUM_SLOTS-1:0]          r_init;
    logic [XW-1:0]                 id_x;
    logic [XW-1:0]                 pair;
    logic [tspa_pkg::ID_W-1:0]     first;
    logic                          wide;
    logic [NUM_SLOTS-1:0]          first_mask;
    logic [NUM_SLOTS-1:0]          cover_mask;

    assign id_x  = {1'b0, i_id};
    assign wide  = id_x >= NUM_SL_V;
    assign pair  = id_x - NUM_SL_V;
    // pair k covers slots 2k+1 and 2k+2
    assign first = wide ? {pair[tspa_pkg::ID_W-2:0], 1'b1} : i_id;

    assign first_mask = {{(NUM_SLOTS-1){1'b0}}, 1'b1} << first;
    assign cover_mask = first_mask | (wide ? (first_mask << 1) : '0);

    assign o_stat.id_valid   = id_x <= LAST_ID_V;
    assign o_stat.wide       = wide;
    assign o_stat.all_free   = &(r_free | ~cover_mask);
    assign o_stat.first_free = |(r_free & first_mask);
    assign o_stat.first_init = |(r_init & first_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_init <= '0;
        end else if (i_init_wr) begin
            r_free <= r_free & ~cover_mask;
            r_init <= r_init | first_mask;
        end else if (i_release_wr) begin
            r_free <= r_free | cover_mask;
            r_init <= r_init & ~first_mask;
        end
    end

endmodule

// File: rtl/tspa_dp.sv
// Datapath: request latch, slot table, ns scaling, prescaler search,
// bit-serial divider and output register. Depends on tspa_pkg and tspa_slots.
module tspa_dp #(
    parameter int NUM_SLOTS = tspa_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tspa_pkg::t_cmd                    i_cmd,
    output tspa_pkg::t_stat                   o_stat,
    input  logic [1:0]                        i_mode,
    input  logic [tspa_pkg::IN_DATA_W-1:0]    i_data,
    input  logic                              i_cfg_wr,
    input  logic [tspa_pkg::CYC_W-1:0]        i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tspa_pkg::OUT_DATA_W-1:0]   o_out_data
);

    localparam int TW = tspa_pkg::T_W;

    tspa_pkg::t_mode                  r_mode;
    logic [tspa_pkg::ID_W-1:0]        r_id;
    logic [tspa_pkg::SAMPLE_W-1:0]    r_sample;
    logic [tspa_pkg::UNIT_W-1:0]      r_unit;
    logic [tspa_pkg::CYC_W-1:0]       r_cyc;

    logic [TW-1:0]                    r_t;
    logic [tspa_pkg::CL_W-1:0]        r_cyc_lim;
    logic [1:0]                       r_k;
    logic [TW-1:0]                    r_q;
    logic [tspa_pkg::CYC_W-1:0]       r_rem;
    logic [tspa_pkg::DIV_CNT_W-1:0]   r_cnt;

    tspa_pkg::t_status                r_status;
    logic                             r_free_flag;
    logic                             r_pvalid;
    logic [1:0]                       r_code;
    logic [tspa_pkg::COUNT_W-1:0]     r_count;
    logic                             r_wide;
    logic                             r_ovalid;
    logic [tspa_pkg::OUT_DATA_W-1:0]  r_odata;

    tspa_pkg::t_slot_stat             slot;
    tspa_pkg::t_status                lookup_status;
    logic                             calc_req;
    logic                             u_ok;
    logic                             init_wr;
    logic                             release_wr;
    logic [TW-1:0]                    mul_full;
    logic [TW-1:0]                    presc_lim;
    logic [tspa_pkg::CYC_W:0]         trial;
    logic                             ge;
    logic [tspa_pkg::CYC_W:0]         diff;

    tspa_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_id         (r_id),
        .i_init_wr    (init_wr),
        .i_release_wr (release_wr),
        .o_stat       (slot)
    );

    assign u_ok     = tspa_pkg::unit_ok(r_unit);
    assign calc_req = slot.id_valid && u_ok &&
                      (((r_mode == tspa_pkg::MODE_INIT) && slot.all_free) ||
                       ((r_mode == tspa_pkg::MODE_SET) && slot.first_init));

    assign init_wr    = i_cmd.lookup && slot.id_valid &&
                        (r_mode == tspa_pkg::MODE_INIT) && slot.all_free;
    assign release_wr = i_cmd.lookup && slot.id_valid && (r_mode == tspa_pkg::MODE_RELEASE);

    always_comb begin
        priority if (!slot.id_valid) begin
            lookup_status = tspa_pkg::ST_INVALID;
        end else begin
            unique case (r_mode)
                tspa_pkg::MODE_INIT: begin
                    lookup_status = slot.all_free ? tspa_pkg::ST_OK : tspa_pkg::ST_IN_USE;
                end
                tspa_pkg::MODE_SET: begin
                    priority if (!slot.first_init) lookup_status = tspa_pkg::ST_NOT_INIT;
                    else if (!u_ok)                lookup_status = tspa_pkg::ST_BAD_UNIT;
                    else                           lookup_status = tspa_pkg::ST_OK;
                end
                default: lookup_status = tspa_pkg::ST_OK;
            endcase
        end
    end

    assign mul_full  = {{tspa_pkg::SCALE_W{1'b0}}, r_sample} *
                       {{tspa_pkg::SAMPLE_W{1'b0}}, tspa_pkg::unit_scale(r_unit)};
    assign presc_lim = {{(TW-tspa_pkg::CL_W){1'b0}}, r_cyc_lim} << tspa_pkg::presc_shift(r_k);

    // restoring divide step by the cycle time
    assign trial = {r_rem, r_q[TW-1]};
    assign ge    = trial >= {1'b0, r_cyc};
    assign diff  = trial - {1'b0, r_cyc};

    assign o_stat.calc_req   = calc_req;
    assign o_stat.lo_bad     = (r_cyc == '0) || (r_t < {{(TW-tspa_pkg::CYC_W){1'b0}}, r_cyc});
    assign o_stat.presc_fit  = r_t <= presc_lim;
    assign o_stat.presc_last = r_k == tspa_pkg::PRESC_256;
    assign o_stat.div_last   = r_cnt == '0;
    assign o_stat.out_busy   = r_ovalid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyc <= tspa_pkg::CYC_RST;
        end else if (i_cfg_wr) begin
            r_cyc <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= tspa_pkg::t_mode'(i_mode);
            r_id     <= i_data[3:0];
            r_sample <= i_data[35:4];
            r_unit   <= i_data[39:36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_status    <= lookup_status;
            r_free_flag <= slot.id_valid && (r_mode == tspa_pkg::MODE_QUERY) && slot.first_free;
            r_wide      <= slot.id_valid && slot.wide;
            r_pvalid    <= 1'b0;
            r_code      <= '0;
            r_count     <= '0;
            r_k         <= tspa_pkg::PRESC_1;
        end
        if (i_cmd.mul) begin
            r_t <= mul_full;
            if (r_wide) begin
                r_cyc_lim <= {r_cyc, 32'b0} - {{32{1'b0}}, r_cyc};
            end else begin
                r_cyc_lim <= {{16{1'b0}}, r_cyc, 16'b0} - {{32{1'b0}}, r_cyc};
            end
        end
        // init reports ok even when no setting fits
        if (i_cmd.fail_range && (r_mode == tspa_pkg::MODE_SET)) begin
            r_status <= tspa_pkg::ST_RANGE;
        end
        if (i_cmd.presc_next) begin
            r_k <= r_k + 2'd1;
        end
        if (i_cmd.div_init) begin
            r_q   <= r_t >> tspa_pkg::presc_shift(r_k);
            r_rem <= '0;
            r_cnt <= tspa_pkg::DIV_CNT_W'(TW - 1);
        end
        if (i_cmd.div_step) begin
            r_q   <= {r_q[TW-2:0], ge};
            r_rem <= ge ? diff[tspa_pkg::CYC_W-1:0] : trial[tspa_pkg::CYC_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.finish) begin
            r_pvalid <= 1'b1;
            r_code   <= r_k;
            r_count  <= r_q[tspa_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= {r_wide, r_count, r_code, r_pvalid, r_free_flag, r_status};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

// File: rtl/tspa_ctrl.sv
// Controller state machine: sequences lookup, scaling, prescaler search and divide.
// Depends on tspa_pkg.
module tspa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tspa_pkg::t_stat i_stat,
    output tspa_pkg::t_cmd  o_cmd
);

    tspa_pkg::t_state r_state;
    tspa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tspa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tspa_pkg::S_IDLE:     if (i_in_valid) n_state = tspa_pkg::S_LOOKUP;
            tspa_pkg::S_LOOKUP:   n_state = i_stat.calc_req ? tspa_pkg::S_MUL : tspa_pkg::S_OUT;
            tspa_pkg::S_MUL:      n_state = tspa_pkg::S_CHECK;
            tspa_pkg::S_CHECK:    n_state = i_stat.lo_bad ? tspa_pkg::S_OUT : tspa_pkg::S_PRESC;
            tspa_pkg::S_PRESC: begin
                priority if (i_stat.presc_fit) n_state = tspa_pkg::S_DIV_INIT;
                else if (i_stat.presc_last)    n_state = tspa_pkg::S_OUT;
                else                           n_state = tspa_pkg::S_PRESC;
            end
            tspa_pkg::S_DIV_INIT: n_state = tspa_pkg::S_DIV;
            tspa_pkg::S_DIV:      if (i_stat.div_last) n_state = tspa_pkg::S_FINISH;
            tspa_pkg::S_FINISH:   n_state = tspa_pkg::S_OUT;
            tspa_pkg::S_OUT:      if (!i_stat.out_busy) n_state = tspa_pkg::S_IDLE;
            default:              n_state = tspa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tspa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tspa_pkg::S_LOOKUP:   o_cmd.lookup = 1'b1;
            tspa_pkg::S_MUL:      o_cmd.mul = 1'b1;
            tspa_pkg::S_CHECK:    o_cmd.fail_range = i_stat.lo_bad;
            tspa_pkg::S_PRESC: begin
                o_cmd.presc_next = !i_stat.presc_fit && !i_stat.presc_last;
                o_cmd.fail_range = !i_stat.presc_fit && i_stat.presc_last;
            end
            tspa_pkg::S_DIV_INIT: o_cmd.div_init = 1'b1;
            tspa_pkg::S_DIV:      o_cmd.div_step = 1'b1;
            tspa_pkg::S_FINISH:   o_cmd.finish = 1'b1;
            tspa_pkg::S_OUT:      o_cmd.out_load = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule

// File: rtl/tspa_checker.sv
// Port-level checker of the timer slot period allocator, bound to the top level.
// Depends on tspa_pkg and timer_slot_period_allocator_top.
module tspa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tspa_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while one is in flight");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no setting means zero prescaler and period
    a_no_setting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[38:5] == '0)
        else $error("period fields set without a valid setting");

    // out of range is the highest status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(tspa_pkg::ST_RANGE))
        else $error("undefined status code");

endmodule

bind timer_slot_period_allocator_top tspa_checker u_tspa_checker (.*);

// File: tb/tb_timer_slot_period_allocator_top.sv
// Self-checking testbench for timer_slot_period_allocator_top: request beats go in,
// a slot ledger predicts every result beat and compares it field by field.
// Depends on rtl/tspa_pkg.sv and the RTL under rtl/ only.
`timescale 1ns / 100ps

module tb_timer_slot_period_allocator_top;
    import tspa_pkg::*;

    localparam int N_SLOTS = 9;
    localparam int LAST_ID = N_SLOTS + (N_SLOTS - 1) / 2 - 1;
    localparam int HALF_PERIOD = 4;

    // Pacing of the two stream sides during one phase of the run.
    typedef enum int {
        PACE_STEADY,
        PACE_SRC_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } pace_t;

    typedef struct {
        t_mode               mode;
        logic [ID_W-1:0]     timer_id;
        logic [SAMPLE_W-1:0] req_time;
        logic [UNIT_W-1:0]   unit;
    } req_t;

    typedef struct {
        t_status            status;
        logic               slot_is_free;
        logic               period_valid;
        logic [1:0]         prescaler_code;
        logic [COUNT_W-1:0] period_count;
        logic               is_wide;
    } reply_t;

    // Slot ledger: mirrors the free and initialized marks plus the cycle time,
    // works out the reply of each accepted request and checks the replies.
    class slot_ledger;
        bit               slot_free [N_SLOTS];
        bit               slot_init [N_SLOTS];
        bit [CYC_W-1:0]   cycle_ns;
        reply_t           pending_replies [$];
        int               n_errors;
        int               n_checked;
        int               n_periods;

        function new();
            foreach (slot_free[i]) begin
                slot_free[i] = 1'b1;
                slot_init[i] = 1'b0;
            end
            cycle_ns  = CYC_RST;
            n_errors  = 0;
            n_checked = 0;
            n_periods = 0;
        endfunction

        function bit [63:0] prescale_ratio(int k);
            case (k)
                0:       return 64'd1;
                1:       return 64'd8;
                2:       return 64'd64;
                default: return 64'd256;
            endcase
        endfunction

        // Scale to ns, range-check, pick the least prescaler that fits, divide.
        function t_status period_setting(bit wide, bit [SAMPLE_W-1:0] sample,
                                         bit [UNIT_W-1:0] unit,
                                         output logic [1:0] code,
                                         output logic [COUNT_W-1:0] count);
            bit [63:0] ns;
            bit [63:0] lim;
            bit [63:0] cyc;
            bit [63:0] quot;
            int        k;
            code  = PRESC_1;
            count = '0;
            if (!(unit == UNIT_S || unit == UNIT_MS || unit == UNIT_US || unit == UNIT_NS))
                return ST_BAD_UNIT;
            ns = 64'(sample);
            for (k = 0; k < 9 - int'(unit); k++)
                ns = ns * 64'd10;
            lim = wide ? 64'h0000_0000_ffff_ffff : 64'h0000_0000_0000_ffff;
            cyc = 64'(cycle_ns);
            if (cyc == 64'd0 || ns < cyc || ns > cyc * 64'd256 * lim)
                return ST_RANGE;
            k = 0;
            while (k < 3 && ns > cyc * lim * prescale_ratio(k))
                k++;
            quot  = ns / (cyc * prescale_ratio(k));
            code  = k[1:0];
            count = quot[COUNT_W-1:0];
            return ST_OK;
        endfunction

        function void note_request(req_t r);
            reply_t e;
            int     first;
            e.status         = ST_OK;
            e.slot_is_free   = 1'b0;
            e.period_valid   = 1'b0;
            e.prescaler_code = PRESC_1;
            e.period_count   = '0;
            e.is_wide        = 1'b0;
            if (int'(r.timer_id) > LAST_ID) begin
                e.status = ST_INVALID;
            end else begin
                e.is_wide = int'(r.timer_id) >= N_SLOTS;
                first = e.is_wide ? (int'(r.timer_id) - N_SLOTS) * 2 + 1 : int'(r.timer_id);
                case (r.mode)
                    MODE_INIT: begin
                        if (!slot_free[first] || (e.is_wide && !slot_free[first + 1])) begin
                            e.status = ST_IN_USE;
                        end else begin
                            slot_init[first] = 1'b1;
                            slot_free[first] = 1'b0;
                            if (e.is_wide)
                                slot_free[first + 1] = 1'b0;
                            e.period_valid = period_setting(e.is_wide, r.req_time, r.unit,
                                                            e.prescaler_code,
                                                            e.period_count) == ST_OK;
                        end
                    end
                    MODE_SET: begin
                        if (!slot_init[first]) begin
                            e.status = ST_NOT_INIT;
                        end else begin
                            e.status = period_setting(e.is_wide, r.req_time, r.unit,
                                                      e.prescaler_code, e.period_count);
                            e.period_valid = e.status == ST_OK;
                        end
                    end
                    MODE_RELEASE: begin
                        slot_init[first] = 1'b0;
                        slot_free[first] = 1'b1;
                        if (e.is_wide)
                            slot_free[first + 1] = 1'b1;
                    end
                    default: begin
                        e.slot_is_free = slot_free[first];
                    end
                endcase
            end
            pending_replies.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                n_errors++;
                $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, seen);
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t e;
            if (pending_replies.size() == 0) begin
                n_errors++;
                $display("%0d ns: unexpected result beat, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            e = pending_replies.pop_front();
            n_checked++;
            if (e.period_valid)
                n_periods++;
            compare_field("status", 32'(e.status), 32'(got.status));
            compare_field("slot_is_free", 32'(e.slot_is_free), 32'(got.slot_is_free));
            compare_field("period_valid", 32'(e.period_valid), 32'(got.period_valid));
            compare_field("prescaler_code", 32'(e.prescaler_code), 32'(got.prescaler_code));
            compare_field("period_count", e.period_count, got.period_count);
            compare_field("is_wide", 32'(e.is_wide), 32'(got.is_wide));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata, from bit 0: timer_id[3:0], req_time[35:4], unit[39:36]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser, from bit 0: mode[1:0]
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata, from bit 0: status[2:0], slot_is_free[3], period_valid[4],
    // prescaler_code[6:5], period_count[38:7], is_wide[39]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CYC_W-1:0]      i_cfg_data;

    slot_ledger ledger;
    int         src_gap_pct    = 0;
    int         sink_stall_pct = 0;
    int         n_requests     = 0;
    int         n_settings     = 0;

    timer_slot_period_allocator_top #(
        .NUM_SLOTS(N_SLOTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Result side: decide the stall at each falling edge so tready is stable
    // across the rising edge where the beat is taken.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Check every accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        reply_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = t_status'(m_axis_tdata[2:0]);
            got.slot_is_free   = m_axis_tdata[3];
            got.period_valid   = m_axis_tdata[4];
            got.prescaler_code = m_axis_tdata[6:5];
            got.period_count   = m_axis_tdata[38:7];
            got.is_wide        = m_axis_tdata[39];
            ledger.check_reply(got);
        end
    end

    function automatic req_t mk_req(t_mode m, int id, logic [SAMPLE_W-1:0] sample,
                                    logic [UNIT_W-1:0] unit);
        req_t r;
        r.mode     = m;
        r.timer_id = id[ID_W-1:0];
        r.req_time = sample;
        r.unit     = unit;
        return r;
    endfunction

    // Random request, steered by the ledger so that most requests follow a
    // sensible slot life: init a free slot, set its period, release it.
    // The rest is noise: any mode on any id, including invalid ids.
    function automatic req_t pick_request();
        req_t      r;
        int        first;
        int        k;
        bit        wide;
        bit [63:0] boundary_ns;
        r.timer_id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, LAST_ID));
        wide = (int'(r.timer_id) >= N_SLOTS) && (int'(r.timer_id) <= LAST_ID);
        if (int'(r.timer_id) > LAST_ID || $urandom_range(0, 99) < 25) begin
            r.mode = t_mode'($urandom_range(0, 3));
        end else begin
            first = wide ? (int'(r.timer_id) - N_SLOTS) * 2 + 1 : int'(r.timer_id);
            if (ledger.slot_free[first] && (!wide || ledger.slot_free[first + 1])) begin
                r.mode = ($urandom_range(0, 5) == 0) ? MODE_QUERY : MODE_INIT;
            end else if (ledger.slot_init[first]) begin
                r.mode = ($urandom_range(0, 3) == 0) ? MODE_RELEASE : MODE_SET;
            end else begin
                r.mode = ($urandom_range(0, 2) == 0) ? MODE_QUERY : MODE_RELEASE;
            end
        end
        // Mostly legal units, now and then any 4-bit code.
        if ($urandom_range(0, 4) == 0) begin
            r.unit = 4'($urandom_range(0, 15));
        end else begin
            case ($urandom_range(0, 3))
                0:       r.unit = UNIT_S;
                1:       r.unit = UNIT_MS;
                2:       r.unit = UNIT_US;
                default: r.unit = UNIT_NS;
            endcase
        end
        case ($urandom_range(0, 9))
            0: r.req_time = $urandom;
            1: r.req_time = $urandom_range(0, 40);
            7, 8, 9: begin
                // Land on or next to a prescaler threshold, in ns.
                k = $urandom_range(0, 3);
                boundary_ns = 64'(ledger.cycle_ns) *
                              (wide ? 64'hffff_ffff : 64'h0000_ffff) *
                              ledger.prescale_ratio(k);
                boundary_ns = boundary_ns + 64'($urandom_range(0, 2)) - 64'd1;
                r.req_time = (boundary_ns > 64'hffff_ffff) ? $urandom
                                                           : boundary_ns[31:0];
                r.unit = UNIT_NS;
            end
            // Spread magnitudes evenly over all bit lengths.
            default: r.req_time = $urandom >> $urandom_range(0, 31);
        endcase
        return r;
    endfunction

    // Present one request beat (after optional idle cycles) and hold it until
    // it is taken. Called and returning at a falling edge.
    task automatic drive_request(input req_t r);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.unit, r.req_time, r.timer_id};
        s_axis_tuser  <= r.mode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        ledger.note_request(r);
        n_requests++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Write cycle_time_ns only with the block idle; every request yields a
    // result, so an empty prediction queue means nothing is in flight.
    task automatic write_cycle_time(input logic [CYC_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        ledger.cycle_ns = value;
        n_settings++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CYC_W-1:0] cycle_value, input pace_t pace,
                             input int n_items);
        write_cycle_time(cycle_value);
        src_gap_pct    = (pace == PACE_SRC_GAPS) ? 49 : (pace == PACE_BOTH) ? 35 : 0;
        sink_stall_pct = (pace == PACE_SINK_STALLS) ? 49 : (pace == PACE_BOTH) ? 35 : 0;
        repeat (n_items)
            drive_request(pick_request());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        ledger = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset cycle time of 25 ns, no idling.
        drive_request(mk_req(MODE_QUERY, 0, 32'd0, UNIT_NS));          // fresh slot is free
        drive_request(mk_req(MODE_SET, 0, 32'd25, UNIT_NS));           // set before init
        drive_request(mk_req(MODE_INIT, 0, 32'd1, UNIT_MS));           // init with a period
        drive_request(mk_req(MODE_INIT, 0, 32'd1, UNIT_MS));           // slot already taken
        drive_request(mk_req(MODE_SET, 0, 32'd0, UNIT_NS));            // zero time
        drive_request(mk_req(MODE_SET, 0, 32'd24, UNIT_NS));           // below the cycle time
        drive_request(mk_req(MODE_SET, 0, 32'd25, UNIT_NS));           // exactly the cycle time
        drive_request(mk_req(MODE_SET, 0, 32'd5, 4'd5));               // unit not a power step
        drive_request(mk_req(MODE_SET, 0, 32'hffff_ffff, UNIT_S));     // far above the limit
        drive_request(mk_req(MODE_SET, 0, 32'd419_424_000, UNIT_NS));  // widest 16-bit setting
        drive_request(mk_req(MODE_SET, 0, 32'd13_107_001, UNIT_NS));   // just past 1:8
        drive_request(mk_req(MODE_QUERY, 0, 32'd0, UNIT_NS));          // now taken
        drive_request(mk_req(MODE_INIT, 9, 32'd1, UNIT_S));            // pair on slots 1 and 2
        drive_request(mk_req(MODE_INIT, 1, 32'd1, UNIT_MS));           // covered by the pair
        drive_request(mk_req(MODE_INIT, 10, 32'd1, 4'hf));             // init, period fails
        drive_request(mk_req(MODE_SET, 10, 32'hffff_ffff, UNIT_S));    // beyond 32-bit limit
        drive_request(mk_req(MODE_SET, 9, 32'hffff_ffff, UNIT_NS));    // full 32-bit sample
        drive_request(mk_req(MODE_INIT, 12, 32'hffff_ffff, UNIT_MS));  // init, out of range
        drive_request(mk_req(MODE_SET, 8, 32'd100, UNIT_US));          // second slot of a pair
        drive_request(mk_req(MODE_RELEASE, 9, 32'd0, UNIT_NS));        // free both slots
        drive_request(mk_req(MODE_INIT, 2, 32'd7, UNIT_US));           // take the second one
        drive_request(mk_req(MODE_INIT, 9, 32'd7, UNIT_US));           // first free, second not
        drive_request(mk_req(MODE_INIT, 13, 32'd7, UNIT_US));          // past the last pair
        drive_request(mk_req(MODE_QUERY, 15, 32'hffff_ffff, 4'hf));    // highest id
        drive_request(mk_req(MODE_RELEASE, 0, 32'd0, UNIT_NS));

        // Random part: cycle-time extremes and every pacing mode.
        run_phase(10'd1, PACE_STEADY, 150);
        run_phase(10'd1000, PACE_SRC_GAPS, 150);
        run_phase(10'd1023, PACE_SINK_STALLS, 150);
        run_phase(10'd0, PACE_BOTH, 40);
        run_phase(10'($urandom_range(1, 1023)), PACE_BOTH, 130);
        run_phase(CYC_RST, PACE_STEADY, 130);

        // Let the last results drain, then watch for stray beats a while longer.
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (ledger.pending_replies.size() != 0) begin
            ledger.n_errors++;
            $display("%0d ns: %0d predicted results never arrived",
                     $time, ledger.pending_replies.size());
        end

        $display("Run: %0d requests over %0d cycle-time writes and four pacing modes,",
                 n_requests, n_settings);
        $display("     %0d results checked, %0d with a period setting, %0d mismatches.",
                 ledger.n_checked, ledger.n_periods, ledger.n_errors);
        if (ledger.n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest legal run.
    initial begin
        #6_000_000;
        $display("Timeout after %0d requests", n_requests);
        $display("FAILURE");
        $finish;
    end

endmodule
